@@ src/rnp_pkg.sv @@
package rnp_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned SqW = 2 * ChanW;
  localparam int unsigned DistW = SqW + 2;
  localparam int unsigned SumW = ChanW + 2;
  localparam int unsigned LvlW = 3;
  localparam int unsigned GreyKW = 5;
  localparam int unsigned GreySteps = 24;
  localparam int unsigned GreyBase = 232;
  localparam int unsigned CubeBase = 16;
  localparam int unsigned GreyStart = 8;
  localparam int unsigned GreyStep = 10;
  localparam int unsigned PipeDepth = 7;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [LvlW-1:0] lvl_t;
  typedef logic [SqW-1:0] sq_t;
  typedef logic [DistW-1:0] dist_t;
  typedef logic [GreyKW-1:0] greyk_t;

  // Nearest cube level for one channel; a value exactly between two levels
  // takes the lower one.
  function automatic lvl_t chan_level(input chan_t c);
    lvl_t l;
    if (c >= chan_t'(236)) l = lvl_t'(5);
    else if (c >= chan_t'(196)) l = lvl_t'(4);
    else if (c >= chan_t'(156)) l = lvl_t'(3);
    else if (c >= chan_t'(116)) l = lvl_t'(2);
    else if (c >= chan_t'(48)) l = lvl_t'(1);
    else l = lvl_t'(0);
    return l;
  endfunction

  function automatic chan_t level_value(input lvl_t l);
    chan_t v;
    unique case (l)
      lvl_t'(0): v = chan_t'(0);
      lvl_t'(1): v = chan_t'(95);
      lvl_t'(2): v = chan_t'(135);
      lvl_t'(3): v = chan_t'(175);
      lvl_t'(4): v = chan_t'(215);
      default: v = chan_t'(255);
    endcase
    return v;
  endfunction

  function automatic chan_t abs_diff(input chan_t a, input chan_t b);
    return (a > b) ? chan_t'(a - b) : chan_t'(b - a);
  endfunction

endpackage

@@ src/rgb_nearest_256_palette_index_top.sv @@
// Throughput: one pixel per cycle unless stalled; cube and grey searches
// run as parallel six-stage pipelines, followed by one select stage.
// A stalled output freezes every stage, so nothing is lost or repeated.
// Reset (synchronous, active high) clears the valid bits only.
module rgb_nearest_256_palette_index_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rnp_pkg::chan_t red,
  input  rnp_pkg::chan_t green,
  input  rnp_pkg::chan_t blue,
  output logic           out_valid,
  input  logic           out_stall,
  output rnp_pkg::chan_t palette_index
);

  logic [rnp_pkg::PipeDepth-2:0] vld;
  logic en;
  rnp_pkg::dist_t cube_dist, grey_lo, grey_hi, grey_dist;
  rnp_pkg::chan_t cube_index, grey_index;
  rnp_pkg::greyk_t grey_k;

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  rnp_cube_path u_cube (
    .clk      (clk),
    .en       (en),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .distance (cube_dist),
    .index    (cube_index)
  );

  rnp_grey_path u_grey (
    .clk     (clk),
    .en      (en),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .dist_lo (grey_lo),
    .dist_hi (grey_hi),
    .k_lo    (grey_k)
  );

  always_comb begin
    if (grey_hi < grey_lo) begin
      grey_dist = grey_hi;
      grey_index = rnp_pkg::chan_t'(rnp_pkg::GreyBase) + rnp_pkg::chan_t'(grey_k)
                 + rnp_pkg::chan_t'(1);
    end else begin
      grey_dist = grey_lo;
      grey_index = rnp_pkg::chan_t'(rnp_pkg::GreyBase) + rnp_pkg::chan_t'(grey_k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[rnp_pkg::PipeDepth-3:0], in_valid};
      out_valid <= vld[rnp_pkg::PipeDepth-2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      palette_index <= (grey_dist < cube_dist) ? grey_index : cube_index;
    end
  end

endmodule

@@ src/rnp_cube_path.sv @@
module rnp_cube_path (
  input  logic               clk,
  input  logic               en,
  input  rnp_pkg::chan_t     red,
  input  rnp_pkg::chan_t     green,
  input  rnp_pkg::chan_t     blue,
  output rnp_pkg::dist_t     distance,
  output rnp_pkg::chan_t     index
);

  rnp_pkg::lvl_t lvl_r, lvl_g, lvl_b;
  rnp_pkg::chan_t r1, g1, b1;
  rnp_pkg::chan_t dr, dg, db;
  rnp_pkg::sq_t sr, sg, sb;
  rnp_pkg::dist_t d4, d5;
  rnp_pkg::chan_t idx1, idx2, idx3, idx4, idx5;
  rnp_pkg::chan_t idx_next;

  assign idx_next = rnp_pkg::chan_t'(rnp_pkg::CubeBase)
                  + rnp_pkg::chan_t'(36) * rnp_pkg::chan_t'(rnp_pkg::chan_level(red))
                  + rnp_pkg::chan_t'(6) * rnp_pkg::chan_t'(rnp_pkg::chan_level(green))
                  + rnp_pkg::chan_t'(rnp_pkg::chan_level(blue));

  always_ff @(posedge clk) begin
    if (en) begin
      lvl_r <= rnp_pkg::chan_level(red);
      lvl_g <= rnp_pkg::chan_level(green);
      lvl_b <= rnp_pkg::chan_level(blue);
      r1 <= red;
      g1 <= green;
      b1 <= blue;
      idx1 <= idx_next;
      dr <= rnp_pkg::abs_diff(rnp_pkg::level_value(lvl_r), r1);
      dg <= rnp_pkg::abs_diff(rnp_pkg::level_value(lvl_g), g1);
      db <= rnp_pkg::abs_diff(rnp_pkg::level_value(lvl_b), b1);
      idx2 <= idx1;
      sr <= dr * dr;
      sg <= dg * dg;
      sb <= db * db;
      idx3 <= idx2;
      d4 <= rnp_pkg::dist_t'(sr) + rnp_pkg::dist_t'(sg) + rnp_pkg::dist_t'(sb);
      idx4 <= idx3;
      d5 <= d4;
      idx5 <= idx4;
      distance <= d5;
      index <= idx5;
    end
  end

endmodule

@@ src/rnp_grey_path.sv @@
module rnp_grey_path (
  input  logic               clk,
  input  logic               en,
  input  rnp_pkg::chan_t     red,
  input  rnp_pkg::chan_t     green,
  input  rnp_pkg::chan_t     blue,
  output rnp_pkg::dist_t     dist_lo,
  output rnp_pkg::dist_t     dist_hi,
  output rnp_pkg::greyk_t    k_lo
);

  localparam int unsigned ThermW = rnp_pkg::GreySteps - 2;

  logic [rnp_pkg::SumW-1:0] sum1;
  logic [ThermW-1:0] therm;
  rnp_pkg::chan_t r1, g1, b1, r2, g2, b2, r3, g3, b3;
  rnp_pkg::greyk_t k3, k4, k5;
  rnp_pkg::chan_t vlo, vhi;
  rnp_pkg::chan_t dlr, dlg, dlb, dhr, dhg, dhb;
  rnp_pkg::sq_t slr, slg, slb, shr, shg, shb;
  logic [ThermW-1:0] therm_next;
  rnp_pkg::greyk_t k_next;

  always_comb begin
    for (int j = 0; j < ThermW; j++) begin
      therm_next[j] = sum1 >= rnp_pkg::SumW'(3 * rnp_pkg::GreyStart
                                             + 3 * rnp_pkg::GreyStep * (j + 1));
    end
    k_next = rnp_pkg::greyk_t'($countones(therm));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum1 <= rnp_pkg::SumW'(red) + rnp_pkg::SumW'(green) + rnp_pkg::SumW'(blue);
      r1 <= red;
      g1 <= green;
      b1 <= blue;
      therm <= therm_next;
      r2 <= r1;
      g2 <= g1;
      b2 <= b1;
      k3 <= k_next;
      vlo <= rnp_pkg::chan_t'(rnp_pkg::GreyStart)
           + rnp_pkg::chan_t'(rnp_pkg::GreyStep) * rnp_pkg::chan_t'(k_next);
      vhi <= rnp_pkg::chan_t'(rnp_pkg::GreyStart + rnp_pkg::GreyStep)
           + rnp_pkg::chan_t'(rnp_pkg::GreyStep) * rnp_pkg::chan_t'(k_next);
      r3 <= r2;
      g3 <= g2;
      b3 <= b2;
      dlr <= rnp_pkg::abs_diff(vlo, r3);
      dlg <= rnp_pkg::abs_diff(vlo, g3);
      dlb <= rnp_pkg::abs_diff(vlo, b3);
      dhr <= rnp_pkg::abs_diff(vhi, r3);
      dhg <= rnp_pkg::abs_diff(vhi, g3);
      dhb <= rnp_pkg::abs_diff(vhi, b3);
      k4 <= k3;
      slr <= dlr * dlr;
      slg <= dlg * dlg;
      slb <= dlb * dlb;
      shr <= dhr * dhr;
      shg <= dhg * dhg;
      shb <= dhb * dhb;
      k5 <= k4;
      dist_lo <= rnp_pkg::dist_t'(slr) + rnp_pkg::dist_t'(slg) + rnp_pkg::dist_t'(slb);
      dist_hi <= rnp_pkg::dist_t'(shr) + rnp_pkg::dist_t'(shg) + rnp_pkg::dist_t'(shb);
      k_lo <= k5;
    end
  end

endmodule

@@ test/palette_match_checker.sv @@
module palette_match_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  rnp_pkg::chan_t red,
  input  rnp_pkg::chan_t green,
  input  rnp_pkg::chan_t blue,
  input  logic           out_valid,
  input  logic           out_stall,
  input  rnp_pkg::chan_t palette_index,
  output int             fail_count,
  output int             pending,
  output int             pixels_in,
  output int             pixels_out
);
  timeunit 1ns;
  timeprecision 1ps;

  rnp_pkg::chan_t expected_index_q[$];

  function automatic int unsigned sq_dist(input int unsigned p, input int unsigned c);
    int d;
    d = int'(p) - int'(c);
    return d * d;
  endfunction

  function automatic rnp_pkg::chan_t nearest_entry(input rnp_pkg::chan_t r,
      input rnp_pkg::chan_t g, input rnp_pkg::chan_t b);
    int unsigned levels[6];
    int unsigned best_dist;
    int unsigned entry_dist;
    int unsigned cr, cg, cb, k;
    int unsigned best;
    levels = '{0, 95, 135, 175, 215, 255};
    best = rnp_pkg::CubeBase;
    best_dist = 32'hFFFF_FFFF;
    for (int unsigned idx = rnp_pkg::CubeBase; idx < 256; idx++) begin
      if (idx < rnp_pkg::GreyBase) begin
        k = idx - rnp_pkg::CubeBase;
        cr = levels[k / 36];
        cg = levels[(k / 6) % 6];
        cb = levels[k % 6];
      end else begin
        cr = (idx - rnp_pkg::GreyBase) * rnp_pkg::GreyStep + rnp_pkg::GreyStart;
        cg = cr;
        cb = cr;
      end
      entry_dist = sq_dist(r, cr) + sq_dist(g, cg) + sq_dist(b, cb);
      if (entry_dist < best_dist) begin
        best_dist = entry_dist;
        best = idx;
      end
    end
    return rnp_pkg::chan_t'(best);
  endfunction

  assign pending = expected_index_q.size();

  always @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
      pixels_in <= 0;
      pixels_out <= 0;
      expected_index_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_index_q.push_back(nearest_entry(red, green, blue));
        pixels_in <= pixels_in + 1;
      end
      if (out_valid && !out_stall) begin
        pixels_out <= pixels_out + 1;
        if (expected_index_q.size() == 0) begin
          $error("Unexpected transaction: palette_index actual %0d", palette_index);
          fail_count <= fail_count + 1;
        end else if (expected_index_q[0] !== palette_index) begin
          $error("Mismatch on palette_index: expected %0d, actual %0d",
                 expected_index_q[0], palette_index);
          fail_count <= fail_count + 1;
          void'(expected_index_q.pop_front());
        end else begin
          void'(expected_index_q.pop_front());
        end
      end
    end
  end
endmodule

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  rnp_pkg::chan_t red;
  rnp_pkg::chan_t green;
  rnp_pkg::chan_t blue;
  logic           out_valid;
  logic           out_stall;
  rnp_pkg::chan_t palette_index;
  int             fail_count;
  int             pending;
  int             pixels_in;
  int             pixels_out;
  int             idle_cycles;
  bit             long_hold;
  bit             quiet_sender;
  bit             quiet_receiver;

  localparam int WatchdogLimit = 2000;

  rgb_nearest_256_palette_index_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .red(red), .green(green), .blue(blue), .out_valid(out_valid),
    .out_stall(out_stall), .palette_index(palette_index)
  );

  palette_match_checker checker_i (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .red(red), .green(green), .blue(blue), .out_valid(out_valid),
    .out_stall(out_stall), .palette_index(palette_index),
    .fail_count(fail_count), .pending(pending), .pixels_in(pixels_in),
    .pixels_out(pixels_out)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b1;
    red = '0;
    green = '0;
    blue = '0;
    long_hold = 1'b0;
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  task automatic send_pixel(input rnp_pkg::chan_t r, input rnp_pkg::chan_t g,
      input rnp_pkg::chan_t b);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // The receiver draws a stall length per result, and once holds off for a
  // long stretch so that the pipeline fills and pushes back on the input.
  initial begin
    int hold;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        long_hold = 1'b0;
      end
      hold = quiet_receiver ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) hold = 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("rgb_nearest_256_palette_index_top test failed");
        $finish;
      end
    end
  end

  initial begin
    int levels[6];
    int ties[6];
    @(negedge clk);
    while (rst) @(negedge clk);
    levels = '{0, 95, 135, 175, 215, 255};
    // Midpoints between cube levels and grey steps exercise tie breaking.
    ties = '{47, 48, 115, 155, 235, 13};
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_pixel(8'd8, 8'd8, 8'd8);
    send_pixel(8'd238, 8'd238, 8'd238);
    send_pixel(8'd4, 8'd4, 8'd4);
    send_pixel(8'd246, 8'd246, 8'd246);
    for (int i = 0; i < 6; i++) begin
      send_pixel(8'(ties[i]), 8'(ties[i]), 8'(ties[i]));
      send_pixel(8'(levels[i]), 8'(ties[5 - i]), 8'(levels[5 - i]));
    end
    long_hold = 1'b1;
    for (int i = 0; i < 60; i++) begin
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < 780; i++) begin
      int mode;
      int v;
      quiet_sender = (i >= 300 && i < 400);
      quiet_receiver = (i >= 350 && i < 450);
      mode = $urandom_range(0, 3);
      v = $urandom_range(0, 255);
      if (mode == 0) begin
        send_pixel(8'(v), 8'(v + $urandom_range(0, 4) - 2), 8'(v));
      end else if (mode == 1) begin
        send_pixel(8'(levels[$urandom_range(0, 5)] + $urandom_range(0, 6) - 3),
                   8'(levels[$urandom_range(0, 5)] + $urandom_range(0, 6) - 3),
                   8'(levels[$urandom_range(0, 5)] + $urandom_range(0, 6) - 3));
      end else begin
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d pixels and checked %0d palette indices, including grey,",
             pixels_in, pixels_out);
    $display("cube tie points, a long output hold-off and back-to-back stretches.");
    if (fail_count == 0) begin
      $display("rgb_nearest_256_palette_index_top test passed");
    end else begin
      $display("rgb_nearest_256_palette_index_top test failed");
    end
    $finish;
  end
endmodule
